// ===== hdl/slack_coalescing_timer_queue_unit_macros.svh =====
// Assertion macros shared by the timer queue RTL.
`ifndef SLACK_COALESCING_TIMER_QUEUE_UNIT_MACROS_SVH
`define SLACK_COALESCING_TIMER_QUEUE_UNIT_MACROS_SVH

// Checked only outside reset.
`define SCQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SCQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/scq_pkg.sv =====
// Types, constants and helper functions of the timer queue.
`default_nettype none
package scq_pkg;
  localparam int TIMER_SLOTS = 16;
  localparam int IDX_W = $clog2(TIMER_SLOTS);
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int ID_W = 4;

  localparam logic signed [63:0] TIME_INF = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [2:0] K_SET     = 3'd0;
  localparam logic [2:0] K_CANCEL  = 3'd1;
  localparam logic [2:0] K_TICK    = 3'd2;
  localparam logic [2:0] K_PRE_SET = 3'd3;
  localparam logic [2:0] K_PRE_CLR = 3'd4;
  localparam logic [2:0] K_THAW    = 3'd5;

  localparam logic [2:0] RK_FIRED = 3'd0;
  localparam logic [2:0] RK_PRE   = 3'd1;
  localparam logic [2:0] RK_PROG  = 3'd2;
  localparam logic [2:0] RK_STOP  = 3'd3;
  localparam logic [2:0] RK_DONE  = 3'd4;
  localparam logic [2:0] RK_ERR   = 3'd5;

  localparam logic [1:0] ORD_NOP = 2'd0;
  localparam logic [1:0] ORD_INS = 2'd1;
  localparam logic [1:0] ORD_REM = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  pos;
    logic [ID_W-1:0]   id;
    logic signed [63:0] tm;
  } ord_cmd_t;

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? TIME_MIN : TIME_INF;
    return r;
  endfunction

  function automatic logic [62:0] mag63(input logic signed [63:0] s);
    logic signed [63:0] n;
    n = -s;
    if (s == TIME_MIN) return '1;
    return s[63] ? n[62:0] : s[62:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/scq_if.sv =====
// Input and result channel interfaces of the timer queue.
`default_nettype none
interface scq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [3:0]         timer_id;
  logic signed [63:0] deadline;
  logic signed [63:0] earliest;
  logic signed [63:0] latest;
  logic signed [63:0] now;
  modport source (output valid, kind, timer_id, deadline, earliest, latest, now,
                  input ready);
  modport sink (input valid, kind, timer_id, deadline, earliest, latest, now,
                output ready);
endinterface

interface scq_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         result_kind;
  logic [3:0]         fired_id;
  logic signed [63:0] time_value;
  logic [62:0]        slack_amount;
  logic               flag;
  logic               last;
  modport source (output valid, result_kind, fired_id, time_value, slack_amount, flag,
                  last, input ready);
  modport sink (input valid, result_kind, fired_id, time_value, slack_amount, flag,
                last, output ready);
endinterface
`default_nettype wire

// ===== hdl/scq_order.sv =====
// Sorted queue store: ids and times by position, shift insert and remove.
`default_nettype none
module scq_order (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire scq_pkg::ord_cmd_t          cmd,
  input  wire logic [scq_pkg::IDX_W-1:0]  rd_idx,
  input  wire logic [scq_pkg::ID_W-1:0]   find_id,
  output logic signed [63:0]              rd_time,
  output logic [scq_pkg::ID_W-1:0]        head_id,
  output logic signed [63:0]              head_time,
  output logic [scq_pkg::IDX_W-1:0]       find_pos,
  output logic [scq_pkg::CNT_W-1:0]       cnt
);
  import scq_pkg::*;

  logic [ID_W-1:0]    ids_r  [TIMER_SLOTS];
  logic signed [63:0] tms_r  [TIMER_SLOTS];
  logic [CNT_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.op == ORD_INS) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.op == ORD_REM) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_slot
    logic [ID_W-1:0]    prv_id, nxt_id;
    logic signed [63:0] prv_tm, nxt_tm;
    if (g > 0) begin : g_prv
      assign prv_id = ids_r[g-1];
      assign prv_tm = tms_r[g-1];
    end else begin : g_prv0
      assign prv_id = '0;
      assign prv_tm = '0;
    end
    if (g < TIMER_SLOTS - 1) begin : g_nxt
      assign nxt_id = ids_r[g+1];
      assign nxt_tm = tms_r[g+1];
    end else begin : g_nxt0
      assign nxt_id = '0;
      assign nxt_tm = '0;
    end
    always_ff @(posedge clk) begin
      if (cmd.op == ORD_INS) begin
        if (IDX_W'(g) == cmd.pos) begin
          ids_r[g] <= cmd.id;
          tms_r[g] <= cmd.tm;
        end else if (IDX_W'(g) > cmd.pos) begin
          ids_r[g] <= prv_id;
          tms_r[g] <= prv_tm;
        end
      end else if (cmd.op == ORD_REM && IDX_W'(g) >= cmd.pos) begin
        ids_r[g] <= nxt_id;
        tms_r[g] <= nxt_tm;
      end
    end
  end

  always_comb begin
    find_pos = '0;
    for (int k = 0; k < TIMER_SLOTS; k++) begin
      if (CNT_W'(k) < cnt_r && ids_r[k] == find_id) find_pos = IDX_W'(k);
    end
  end

  assign rd_time   = tms_r[rd_idx];
  assign head_id   = ids_r[0];
  assign head_time = tms_r[0];
  assign cnt       = cnt_r;
endmodule
`default_nettype wire

// ===== hdl/slack_coalescing_timer_queue_unit.sv =====
// Timer queue with slack coalescing: a deadline-sorted queue under a small sequencer.
// Usage: one item enters on in_ch (valid/ready), kind selects set, cancel, tick,
// preempt set, preempt cancel or thaw. Each item yields one or more results on
// out_ch, the final one with last set. in_ready is high only while no item is in
// work; the next item can be taken in the cycle after the final result is handed to
// the output register, so a result may still wait for the receiver.
// Set walks the sorted queue one entry per cycle with combinational compare and
// saturating subtract logic, then inserts the new timer at the position found.
// Tick pops one due timer per cycle while out_ch is not stalled. A stall on out_ch
// holds the sequencer in place and nothing is lost. Synchronous active-low reset
// empties the queue and sets the platform and preemption deadlines to infinite;
// stored times and slack are written before they are read, so they need no clearing.
`default_nettype none
`include "slack_coalescing_timer_queue_unit_macros.svh"
module slack_coalescing_timer_queue_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  scq_in_if.sink    in_ch,
  scq_out_if.source out_ch
);
  import scq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_WALK     = 3'd1;
  localparam logic [2:0] S_CANCEL   = 3'd2;
  localparam logic [2:0] S_TICK_PRE = 3'd3;
  localparam logic [2:0] S_TICK_POP = 3'd4;
  localparam logic [2:0] S_UPD      = 3'd5;
  localparam logic [2:0] S_STOP     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [ID_W-1:0]          id_r, id_nxt;
  logic signed [63:0]       dl_r, dl_nxt, lo_r, lo_nxt, hi_r, hi_nxt, now_r, now_nxt;
  logic [CNT_W-1:0]         j_r, j_nxt;
  logic signed [63:0]       e_r, e_nxt, te_r, te_nxt, d_r, d_nxt;
  logic signed [63:0]       plat_r, plat_nxt, pre_r, pre_nxt;
  logic [TIMER_SLOTS-1:0]   mask_r, mask_nxt;
  logic [62:0]              slack_r [TIMER_SLOTS];
  logic                     slk_we;
  logic [62:0]              slk_wd;
  logic [2:0]               dn_kind_r, dn_kind_nxt;
  logic [ID_W-1:0]          dn_id_r, dn_id_nxt;
  logic signed [63:0]       dn_time_r, dn_time_nxt;
  logic [62:0]              dn_slack_r, dn_slack_nxt;
  logic                     dn_flag_r, dn_flag_nxt;

  logic                     ov_r, ov_nxt, o_flag_r, o_flag_nxt, o_last_r, o_last_nxt;
  logic [2:0]               o_kind_r, o_kind_nxt;
  logic [ID_W-1:0]          o_id_r, o_id_nxt;
  logic signed [63:0]       o_time_r, o_time_nxt;
  logic [62:0]              o_slack_r, o_slack_nxt;

  ord_cmd_t                 cmd;
  logic signed [63:0]       rd_time, head_time;
  logic [ID_W-1:0]          head_id;
  logic [IDX_W-1:0]         find_pos;
  logic [CNT_W-1:0]         cnt;

  logic                     emit_ok, do_emit, e_flag, e_last;
  logic [2:0]               e_kind;
  logic [ID_W-1:0]          e_id;
  logic signed [63:0]       e_time;
  logic [62:0]              e_slack;
  logic                     nxv, cont, ins, ins_co;
  logic [IDX_W-1:0]         ins_pos;
  logic signed [63:0]       ins_tm;

  scq_order u_order (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_idx    (j_r[IDX_W-1:0]),
    .find_id   (id_r),
    .rd_time   (rd_time),
    .head_id   (head_id),
    .head_time (head_time),
    .find_pos  (find_pos),
    .cnt       (cnt)
  );

  assign emit_ok = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // walk decision for entry j-1 (held in e_r) against entry j (rd_time)
  assign nxv  = (j_r < cnt);
  assign cont = (e_r < dl_r) && ((e_r < lo_r) || (nxv && ((rd_time <= dl_r) ||
                (rd_time < hi_r && sat_sub(rd_time, dl_r) < te_r))));

  always_comb begin
    state_nxt = state_r;
    id_nxt = id_r; dl_nxt = dl_r; lo_nxt = lo_r; hi_nxt = hi_r; now_nxt = now_r;
    j_nxt = j_r; e_nxt = e_r; te_nxt = te_r; d_nxt = d_r;
    plat_nxt = plat_r; pre_nxt = pre_r; mask_nxt = mask_r;
    dn_kind_nxt = dn_kind_r; dn_id_nxt = dn_id_r; dn_time_nxt = dn_time_r;
    dn_slack_nxt = dn_slack_r; dn_flag_nxt = dn_flag_r;
    cmd = '0;
    slk_we = 1'b0; slk_wd = '0;
    do_emit = 1'b0; e_kind = RK_DONE; e_id = '0; e_time = '0; e_slack = '0;
    e_flag = 1'b0; e_last = 1'b0;
    ins = 1'b0; ins_co = 1'b0; ins_pos = '0; ins_tm = dl_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          id_nxt = in_ch.timer_id; dl_nxt = in_ch.deadline; lo_nxt = in_ch.earliest;
          hi_nxt = in_ch.latest; now_nxt = in_ch.now;
          j_nxt = '0;
          dn_kind_nxt = RK_DONE; dn_id_nxt = '0; dn_time_nxt = '0;
          dn_slack_nxt = '0; dn_flag_nxt = 1'b0;
          case (in_ch.kind)
            K_SET: begin
              if (mask_r[in_ch.timer_id] || cnt >= CNT_W'(TIMER_SLOTS)) begin
                dn_kind_nxt = RK_ERR; dn_id_nxt = in_ch.timer_id;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            K_CANCEL: begin
              dn_id_nxt = in_ch.timer_id;
              j_nxt = CNT_W'(1);
              state_nxt = mask_r[in_ch.timer_id] ? S_CANCEL : S_DONE;
            end
            K_TICK: begin
              plat_nxt = TIME_INF;
              state_nxt = S_TICK_PRE;
            end
            K_PRE_SET: begin
              pre_nxt = in_ch.deadline;
              d_nxt = in_ch.deadline;
              state_nxt = S_UPD;
            end
            K_PRE_CLR: begin
              pre_nxt = TIME_INF;
              state_nxt = S_DONE;
            end
            K_THAW: begin
              plat_nxt = TIME_INF;
              d_nxt = (cnt != '0 && head_time < pre_r) ? head_time : pre_r;
              state_nxt = S_UPD;
            end
            default: begin
              dn_kind_nxt = RK_ERR;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (j_r == '0) begin
          if (cnt == '0) begin
            ins = 1'b1;
          end else begin
            e_nxt = rd_time;
            te_nxt = sat_sub(dl_r, rd_time);
            j_nxt = CNT_W'(1);
          end
        end else if (e_r > hi_r) begin
          ins = 1'b1;
          ins_pos = IDX_W'(j_r - 1'b1);
        end else if (cont) begin
          if (nxv) begin
            e_nxt = rd_time;
            te_nxt = sat_sub(dl_r, rd_time);
            j_nxt = j_r + 1'b1;
          end else begin
            ins = 1'b1;
            ins_pos = cnt[IDX_W-1:0];
          end
        end else begin
          // join the entry just passed, shifted by the slack
          ins = 1'b1;
          ins_co = 1'b1;
          ins_pos = j_r[IDX_W-1:0];
          ins_tm = e_r;
        end
        if (ins) begin
          cmd.op = ORD_INS; cmd.pos = ins_pos; cmd.id = id_r; cmd.tm = ins_tm;
          slk_we = 1'b1;
          slk_wd = ins_co ? mag63(te_r) : '0;
          mask_nxt[id_r] = 1'b1;
          dn_id_nxt = id_r; dn_time_nxt = ins_tm; dn_slack_nxt = slk_wd;
          dn_flag_nxt = ins_co;
          d_nxt = dl_r;
          state_nxt = (ins_pos == '0) ? S_UPD : S_DONE;
        end
      end
      S_CANCEL: begin
        cmd.op = ORD_REM; cmd.pos = find_pos;
        mask_nxt[id_r] = 1'b0;
        dn_flag_nxt = 1'b1;
        d_nxt = rd_time;
        if (find_pos != '0) begin
          state_nxt = S_DONE;
        end else if (cnt > CNT_W'(1)) begin
          state_nxt = S_UPD;
        end else if (plat_r == TIME_INF) begin
          state_nxt = S_STOP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TICK_PRE: begin
        if (now_r >= pre_r) begin
          if (emit_ok) begin
            do_emit = 1'b1; e_kind = RK_PRE; e_time = now_r;
            pre_nxt = TIME_INF;
            state_nxt = S_TICK_POP;
          end
        end else begin
          state_nxt = S_TICK_POP;
        end
      end
      S_TICK_POP: begin
        if (cnt != '0 && now_r >= head_time) begin
          if (emit_ok) begin
            do_emit = 1'b1; e_kind = RK_FIRED; e_id = head_id; e_time = head_time;
            e_slack = slack_r[head_id];
            cmd.op = ORD_REM; cmd.pos = '0;
            mask_nxt[head_id] = 1'b0;
          end
        end else begin
          d_nxt = (cnt != '0 && head_time < pre_r) ? head_time : pre_r;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (d_r < plat_r) begin
          if (emit_ok) begin
            do_emit = 1'b1; e_kind = RK_PROG; e_time = d_r;
            plat_nxt = d_r;
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_STOP: begin
        if (emit_ok) begin
          do_emit = 1'b1; e_kind = RK_STOP;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (emit_ok) begin
          do_emit = 1'b1; e_kind = dn_kind_r; e_id = dn_id_r; e_time = dn_time_r;
          e_slack = dn_slack_r; e_flag = dn_flag_r; e_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ov_nxt = ov_r && !out_ch.ready;
    o_kind_nxt = o_kind_r; o_id_nxt = o_id_r; o_time_nxt = o_time_r;
    o_slack_nxt = o_slack_r; o_flag_nxt = o_flag_r; o_last_nxt = o_last_r;
    if (do_emit) begin
      ov_nxt = 1'b1;
      o_kind_nxt = e_kind; o_id_nxt = e_id; o_time_nxt = e_time;
      o_slack_nxt = e_slack; o_flag_nxt = e_flag; o_last_nxt = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      mask_r  <= '0;
      plat_r  <= TIME_INF;
      pre_r   <= TIME_INF;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      mask_r  <= mask_nxt;
      plat_r  <= plat_nxt;
      pre_r   <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt; dl_r <= dl_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; now_r <= now_nxt;
    j_r <= j_nxt; e_r <= e_nxt; te_r <= te_nxt; d_r <= d_nxt;
    dn_kind_r <= dn_kind_nxt; dn_id_r <= dn_id_nxt; dn_time_r <= dn_time_nxt;
    dn_slack_r <= dn_slack_nxt; dn_flag_r <= dn_flag_nxt;
    o_kind_r <= o_kind_nxt; o_id_r <= o_id_nxt; o_time_r <= o_time_nxt;
    o_slack_r <= o_slack_nxt; o_flag_r <= o_flag_nxt; o_last_r <= o_last_nxt;
    if (slk_we) slack_r[id_r] <= slk_wd;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.result_kind  = o_kind_r;
  assign out_ch.fired_id     = o_id_r;
  assign out_ch.time_value   = o_time_r;
  assign out_ch.slack_amount = o_slack_r;
  assign out_ch.flag         = o_flag_r;
  assign out_ch.last         = o_last_r;

  `SCQ_ASSERT(a_cnt_mask, ($countones(mask_r) == int'(cnt)), "queued mask and count disagree")
  `SCQ_ASSERT(a_cnt_max, (cnt <= CNT_W'(TIMER_SLOTS)), "queue count beyond slots")
  `SCQ_ASSERT(a_busy, (in_ch.valid && in_ch.ready |=> !in_ch.ready), "item taken while busy")
  `SCQ_ASSERT_ALWAYS(a_rst_idle, (!rst_n |=> !out_ch.valid), "result valid after reset")
endmodule
`default_nettype wire

// ===== sim/slack_coalescing_timer_queue_unit_tb.sv =====
// Self-checking bench for the timer queue: directed table, then random ops against a predictor.
module slack_coalescing_timer_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scq_pkg::*;

  typedef struct packed {
    logic [2:0]         rkind;
    logic [3:0]         id;
    logic signed [63:0] tval;
    logic [62:0]        slack;
    logic               flag;
    logic               last;
  } tq_result_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         id;
    logic signed [63:0] dl;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] now;
  } tq_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  scq_in_if  in_ch();
  scq_out_if out_ch();

  slack_coalescing_timer_queue_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow of the queue.
  logic [3:0]         q_order [TIMER_SLOTS];
  int                 q_len;
  logic signed [63:0] q_time  [TIMER_SLOTS];
  logic signed [63:0] q_slack [TIMER_SLOTS];
  logic [15:0]        q_mask;
  logic signed [63:0] plat_dl;
  logic signed [63:0] pre_dl;

  tq_result_t pending_results[$];
  int errors = 0;
  bit sending_done = 0;

  function automatic logic signed [63:0] diff_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? TIME_MIN : TIME_INF;
    return r;
  endfunction

  function automatic logic [62:0] abs63(logic signed [63:0] s);
    logic signed [63:0] n;
    n = -s;
    if (s == TIME_MIN) return '1;
    return s[63] ? n[62:0] : s[62:0];
  endfunction

  task automatic push_result(logic [2:0] k, logic [3:0] id, logic signed [63:0] t,
                             logic [62:0] s, logic f);
    tq_result_t r;
    r = '{rkind: k, id: id, tval: t, slack: s, flag: f, last: 1'b0};
    pending_results.push_back(r);
  endtask

  task automatic arm_platform(logic signed [63:0] d);
    if (d < plat_dl) begin
      plat_dl = d;
      push_result(RK_PROG, 0, d, 0, 0);
    end
  endtask

  function automatic void place(int pos, logic [3:0] id);
    for (int j = q_len; j > pos; j--) q_order[j] = q_order[j-1];
    q_order[pos] = id;
    q_len++;
  endfunction

  task automatic drop(int pos);
    for (int j = pos; j < q_len - 1; j++) q_order[j] = q_order[j+1];
    q_len--;
  endtask

  function automatic bit insert_timer(logic [3:0] id, logic signed [63:0] t,
                                      logic signed [63:0] lo, logic signed [63:0] hi);
    logic signed [63:0] e, nx;
    for (int i = 0; i < q_len; i++) begin
      e = q_time[q_order[i]];
      if (e > hi) begin
        q_slack[id] = 0; q_time[id] = t; place(i, id);
        return 0;
      end
      if (e < t) begin
        if (e < lo) continue;
        if (i + 1 < q_len) begin
          nx = q_time[q_order[i+1]];
          if (nx <= t) continue;
          if (nx < hi && diff_sat(nx, t) < diff_sat(t, e)) continue;
        end
      end
      q_slack[id] = diff_sat(e, t); q_time[id] = e; place(i + 1, id);
      return 1;
    end
    q_slack[id] = 0; q_time[id] = t; place(q_len, id);
    return 0;
  endfunction

  task automatic predict_op(tq_op_t op);
    int start, pos;
    bit co, was_head;
    logic signed [63:0] d;
    logic [3:0] h;
    start = pending_results.size();
    case (op.kind)
      K_SET: begin
        if (q_mask[op.id] || q_len >= TIMER_SLOTS) begin
          push_result(RK_ERR, op.id, 0, 0, 0);
        end else begin
          co = insert_timer(op.id, op.dl, op.lo, op.hi);
          q_mask[op.id] = 1;
          if (q_order[0] == op.id) arm_platform(op.dl);
          push_result(RK_DONE, op.id, q_time[op.id], abs63(q_slack[op.id]), co);
        end
      end
      K_CANCEL: begin
        if (!q_mask[op.id]) begin
          push_result(RK_DONE, op.id, 0, 0, 0);
        end else begin
          was_head = (q_order[0] == op.id);
          pos = 0;
          for (int i = 0; i < q_len; i++) if (q_order[i] == op.id) pos = i;
          drop(pos);
          q_mask[op.id] = 0;
          if (was_head) begin
            if (q_len > 0) arm_platform(q_time[q_order[0]]);
            else if (plat_dl == TIME_INF) push_result(RK_STOP, 0, 0, 0, 0);
          end
          push_result(RK_DONE, op.id, 0, 0, 1);
        end
      end
      K_TICK: begin
        d = TIME_INF;
        plat_dl = TIME_INF;
        if (op.now >= pre_dl) begin
          pre_dl = TIME_INF;
          push_result(RK_PRE, 0, op.now, 0, 0);
        end
        while (q_len > 0 && op.now >= q_time[q_order[0]]) begin
          h = q_order[0];
          drop(0);
          q_mask[h] = 0;
          push_result(RK_FIRED, h, q_time[h], abs63(q_slack[h]), 0);
        end
        if (q_len > 0) d = q_time[q_order[0]];
        if (pre_dl < d) d = pre_dl;
        arm_platform(d);
        push_result(RK_DONE, 0, 0, 0, 0);
      end
      K_PRE_SET: begin
        pre_dl = op.dl;
        arm_platform(op.dl);
        push_result(RK_DONE, 0, 0, 0, 0);
      end
      K_PRE_CLR: begin
        pre_dl = TIME_INF;
        push_result(RK_DONE, 0, 0, 0, 0);
      end
      K_THAW: begin
        d = pre_dl;
        plat_dl = TIME_INF;
        if (q_len > 0 && q_time[q_order[0]] < d) d = q_time[q_order[0]];
        arm_platform(d);
        push_result(RK_DONE, 0, 0, 0, 0);
      end
      default: push_result(RK_ERR, 0, 0, 0, 0);
    endcase
    if (pending_results.size() > start)
      pending_results[pending_results.size()-1].last = 1'b1;
  endtask

  // Directed table; typed expectation only on rows whose result is obvious.
  typedef struct {
    tq_op_t     op;
    bit         typed;
    tq_result_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(logic [2:0] k, logic [3:0] id, logic signed [63:0] dl,
                         logic signed [63:0] lo, logic signed [63:0] hi,
                         logic signed [63:0] now, bit typed = 0,
                         tq_result_t res = '0);
    dir_row_t r;
    r.op = '{kind: k, id: id, dl: dl, lo: lo, hi: hi, now: now};
    r.typed = typed;
    r.res = res;
    dir_rows.push_back(r);
  endtask

  task automatic build_table();
    // after reset: cancel of an unqueued timer, lone result
    add_row(K_CANCEL, 4'd15, 0, 0, 0, 0, 1, '{RK_DONE, 4'd15, 0, 0, 1'b0, 1'b1});
    add_row(3'd6, 4'd0, 0, 0, 0, 0, 1, '{RK_ERR, 4'd0, 0, 0, 1'b0, 1'b1});
    add_row(3'd7, 4'd9, TIME_INF, 0, 0, 0, 1, '{RK_ERR, 4'd0, 0, 0, 1'b0, 1'b1});
    add_row(K_PRE_CLR, 0, 0, 0, 0, 0, 1, '{RK_DONE, 4'd0, 0, 0, 1'b0, 1'b1});
    add_row(K_SET, 4'd0, TIME_MIN, TIME_MIN, TIME_MIN, 0);
    add_row(K_SET, 4'd0, 5, 0, 10, 0);              // already queued -> error
    add_row(K_SET, 4'd15, TIME_INF, TIME_MIN, TIME_INF, 0);
    add_row(K_SET, 4'd3, 100, 50, 200, 0);
    add_row(K_SET, 4'd4, 120, 90, 300, 0);          // coalesce late or early
    add_row(K_SET, 4'd5, 110, 105, 115, 0);
    add_row(K_SET, 4'd6, 1000, 2000, 500, 0);       // inverted window
    add_row(K_CANCEL, 4'd0, 0, 0, 0, 0);            // cancel head
    add_row(K_CANCEL, 4'd4, 0, 0, 0, 0);
    add_row(K_PRE_SET, 0, 50, 0, 0, 0);
    add_row(K_THAW, 0, 0, 0, 0, 0);
    add_row(K_TICK, 0, 0, 0, 0, 150);
    add_row(K_PRE_SET, 0, TIME_MIN, 0, 0, 0);
    add_row(K_PRE_CLR, 0, 0, 0, 0, 0);
    add_row(K_TICK, 0, 0, 0, 0, TIME_INF);          // drains everything
    add_row(K_SET, 4'd7, -5, -9, -1, 0);
    add_row(K_CANCEL, 4'd7, 0, 0, 0, 0);            // empties queue, maybe stop
    add_row(K_SET, 4'd8, TIME_MIN, TIME_MIN, TIME_INF, 0);
    add_row(K_SET, 4'd9, TIME_INF, TIME_MIN, TIME_INF, 0);  // saturating slack
    add_row(K_TICK, 0, 0, 0, 0, TIME_MIN);
    add_row(K_THAW, 0, 0, 0, 0, 0);
  endtask

  function automatic logic signed [63:0] rand_time(logic signed [63:0] base);
    case ($urandom_range(0, 9))
      0: return TIME_MIN;
      1: return TIME_INF;
      2: return {$urandom, $urandom};
      default: return base + $signed(64'($urandom_range(0, 400))) - 64'sd200;
    endcase
  endfunction

  function automatic tq_op_t rand_op(logic signed [63:0] clock_now);
    tq_op_t op;
    logic signed [63:0] t;
    int sel;
    op = '0;
    sel = $urandom_range(0, 99);
    op.id = 4'($urandom_range(0, 15));
    op.now = {$urandom, $urandom};
    if (sel < 45) begin
      op.kind = K_SET;
      t = rand_time(clock_now + 200);
      op.dl = t;
      op.lo = ($urandom_range(0, 7) == 0) ? rand_time(t) : t - $urandom_range(0, 60);
      op.hi = ($urandom_range(0, 7) == 0) ? rand_time(t) : t + $urandom_range(0, 60);
    end else if (sel < 60) begin
      op.kind = K_CANCEL;
    end else if (sel < 80) begin
      op.kind = K_TICK;
      op.now = ($urandom_range(0, 15) == 0) ? rand_time(clock_now) : clock_now;
    end else if (sel < 88) begin
      op.kind = K_PRE_SET;
      op.dl = rand_time(clock_now + 100);
    end else if (sel < 92) begin
      op.kind = K_PRE_CLR;
    end else if (sel < 97) begin
      op.kind = K_THAW;
    end else begin
      op.kind = 3'($urandom_range(6, 7));
    end
    if ($urandom_range(0, 3) == 0) begin
      op.lo = {$urandom, $urandom};
      op.hi = {$urandom, $urandom};
    end
    return op;
  endfunction

  // valid stays high into the next item when no idle cycles are drawn
  task automatic send_op(tq_op_t op);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= op.kind;
    in_ch.timer_id <= op.id;
    in_ch.deadline <= op.dl;
    in_ch.earliest <= op.lo;
    in_ch.latest   <= op.hi;
    in_ch.now      <= op.now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    tq_op_t op;
    logic signed [63:0] clock_now;
    in_ch.valid = 0;
    in_ch.kind = 0;
    in_ch.timer_id = 0;
    in_ch.deadline = 0;
    in_ch.earliest = 0;
    in_ch.latest = 0;
    in_ch.now = 0;
    q_len = 0;
    q_mask = 0;
    plat_dl = TIME_INF;
    pre_dl = TIME_INF;
    build_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        pending_results.push_back(dir_rows[i].res);
        // keep shadow state in step; typed rows don't change it
      end else begin
        predict_op(dir_rows[i].op);
      end
      send_op(dir_rows[i].op);
    end

    clock_now = 0;
    repeat (305) begin
      // time mostly moves forward so timers come due in order
      if (pending_results.size() == 0 && $urandom_range(0, 1)) clock_now += 0;
      clock_now += $urandom_range(0, 40);
      op = rand_op(clock_now);
      predict_op(op);
      send_op(op);
    end
    in_ch.valid <= 1'b0;
    sending_done = 1;
  end

  // Result side: random stalls, compare against oldest expectation.
  initial begin
    tq_result_t want, got;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.result_kind, out_ch.fired_id, out_ch.time_value,
              out_ch.slack_amount, out_ch.flag, out_ch.last};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: got %p", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
